// ----- rtl/tpid_pkg.sv -----
// Shared constants, types and register indexes of the two-axis PID unit.
// Used by every file under rtl; depends on nothing.
package tpid_pkg;

	localparam int TOUCH_BITS  = 10;
	localparam int MOTOR_COUNT = 3;
	localparam int AXES        = 2;

	localparam int GAIN_W   = 24;
	localparam int CENTER_W = 10;
	localparam int TARGET_W = 10;
	localparam int POS_W    = 16;
	localparam int SGAIN_W  = 8;
	localparam int TLIM_W   = 15;
	localparam int SPEED_W  = 10;
	localparam int TILT_W   = 16;
	localparam int SUM_W    = 32;

	// Error is center minus touch minus target; two bits of headroom cover the sign and carry.
	localparam int ERR_W   = ((TOUCH_BITS > CENTER_W) ? TOUCH_BITS : CENTER_W) + 2;
	localparam int DER_W   = ERR_W + 1;
	localparam int SUMX_W  = SUM_W + 2;
	localparam int GAP_W   = POS_W;
	localparam int SPROD_W = GAP_W + SGAIN_W;
	localparam int SLEW_W  = SPROD_W + 2;
	localparam int PP_W    = GAIN_W + 1 + ERR_W;
	localparam int PI_W    = GAIN_W + 1 + SUM_W;
	localparam int PD_W    = GAIN_W + 1 + DER_W;
	localparam int ACC_W   = PI_W + 2;

	localparam int ROUND_SH   = 9;
	localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
	localparam int SPEED_MAX  = 1000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_SPEED_GAIN,
		CFG_TILT_LIMIT,
		CFG_SPEED_STEP
	} cfg_idx_t;

	localparam logic [GAIN_W-1:0]   RST_GAIN_P     = 24'd6711;
	localparam logic [GAIN_W-1:0]   RST_GAIN_I     = 24'd34;
	localparam logic [GAIN_W-1:0]   RST_GAIN_D     = 24'd117440;
	localparam logic [CENTER_W-1:0] RST_CENTER     = 10'd500;
	localparam logic [SGAIN_W-1:0]  RST_SPEED_GAIN = 8'd20;
	localparam logic [TLIM_W-1:0]   RST_TILT_LIMIT = 15'd8192;
	localparam logic [SPEED_W-1:0]  RST_SPEED_STEP = 10'd200;

	typedef logic [TOUCH_BITS-1:0]    touch_t;
	typedef logic signed [TARGET_W-1:0] target_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [TILT_W-1:0] tilt_t;
	typedef logic [SPEED_W-1:0]       speed_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [DER_W-1:0]  der_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [SUMX_W-1:0] sumx_t;
	typedef logic signed [POS_W:0]    gapd_t;
	typedef logic [SPROD_W-1:0]       sprod_t;
	typedef logic signed [SLEW_W-1:0] slew_t;
	typedef logic signed [PP_W-1:0]   pp_t;
	typedef logic signed [PI_W-1:0]   pi_t;
	typedef logic signed [PD_W-1:0]   pd_t;
	typedef logic signed [ACC_W-1:0]  acc_w_t;
	typedef logic signed [GAIN_W:0]   gain_sx_t;

	localparam sum_t SUM_MAX = 32'sh7fffffff;
	localparam sum_t SUM_MIN = 32'sh80000000;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [SGAIN_W-1:0]  speed_gain;
		logic [TLIM_W-1:0]   tilt_limit;
		logic [SPEED_W-1:0]  speed_step_limit;
	} cfg_t;

	typedef struct packed {
		touch_t                    touch_x;
		touch_t                    touch_y;
		target_t                   target_x;
		target_t                   target_y;
		pos_t [MOTOR_COUNT-1:0]    now_pos;
		pos_t [MOTOR_COUNT-1:0]    goal_pos;
	} s1_item_t;

	typedef struct packed {
		logic                      nz;
		err_t [AXES-1:0]           err;
		sum_t [AXES-1:0]           sum;
		der_t [AXES-1:0]           der;
		sprod_t [MOTOR_COUNT-1:0]  sprod;
	} s2_front_t;

	typedef struct packed {
		logic                      nz;
		pp_t [AXES-1:0]            pp;
		pi_t [AXES-1:0]            pi;
		pd_t [AXES-1:0]            pd;
		speed_t [MOTOR_COUNT-1:0]  speed;
	} s3_prod_t;

	typedef struct packed {
		logic                      nz;
		acc_w_t [AXES-1:0]         acc;
		speed_t [MOTOR_COUNT-1:0]  speed;
	} s4_acc_t;

endpackage

// ----- rtl/tpid_in_if.sv -----
// Sample channel: valid/ready handshake carrying one touch sample and motor positions.
// Depends on tpid_pkg for field widths.
interface tpid_in_if;
	logic                valid;
	logic                ready;
	tpid_pkg::touch_t    touch_x;
	tpid_pkg::touch_t    touch_y;
	tpid_pkg::target_t   target_x;
	tpid_pkg::target_t   target_y;
	tpid_pkg::pos_t      now_pos_a;
	tpid_pkg::pos_t      now_pos_b;
	tpid_pkg::pos_t      now_pos_c;
	tpid_pkg::pos_t      goal_pos_a;
	tpid_pkg::pos_t      goal_pos_b;
	tpid_pkg::pos_t      goal_pos_c;

	modport source (output valid, touch_x, touch_y, target_x, target_y, now_pos_a, now_pos_b,
		now_pos_c, goal_pos_a, goal_pos_b, goal_pos_c, input ready);
	modport sink (input valid, touch_x, touch_y, target_x, target_y, now_pos_a, now_pos_b,
		now_pos_c, goal_pos_a, goal_pos_b, goal_pos_c, output ready);
endinterface

// ----- rtl/tpid_out_if.sv -----
// Command channel: valid/ready handshake carrying tilt commands, motor speeds and ball status.
// Depends on tpid_pkg for field widths.
interface tpid_out_if;
	logic              valid;
	logic              ready;
	tpid_pkg::tilt_t   tilt_x;
	tpid_pkg::tilt_t   tilt_y;
	tpid_pkg::speed_t  speed_a;
	tpid_pkg::speed_t  speed_b;
	tpid_pkg::speed_t  speed_c;
	logic              ball_seen;

	modport source (output valid, tilt_x, tilt_y, speed_a, speed_b, speed_c, ball_seen,
		input ready);
	modport sink (input valid, tilt_x, tilt_y, speed_a, speed_b, speed_c, ball_seen,
		output ready);
endinterface

// ----- rtl/two_axis_pid_with_motor_speed_unit.sv -----
// Two-axis ball-balancing PID with motor speed shaping, top level.
// Depends on tpid_pkg, tpid_in_if, tpid_out_if, tpid_cfg, tpid_front, tpid_mult, tpid_out.
//
// Usage:
//   sample carries one touch beat: touch X/Y, X/Y setpoints and the current and goal
//   step positions of motors A, B and C. A touch X of zero means no ball.
//   command carries one beat per sample: clamped Q1.15 X/Y tilt, three motor speeds
//   in 0..1000 and the ball detect flag.
//   cfg_we/cfg_index/cfg_wdata write the gain, center and limit registers; write them
//   only while no sample is in flight.
// Timing:
//   A sample passes the input, error, multiply and sum registers to the command register.
//   While command is not stalled the pipeline takes one sample per cycle: the error sum
//   closes its loop inside the error stage and the speed slew inside the multiply stage.
// Reset clears the loop state, held tilt, speeds and flags, and loads the default
//   register values. When the command receiver stalls, the output register holds its
//   beat and the four pipeline stages keep filling; sample ready drops only once all
//   of them are full.
module two_axis_pid_with_motor_speed_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	tpid_in_if.sink                          sample,
	tpid_out_if.source                       command,
	input  logic                             cfg_we,
	input  logic [tpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	tpid_pkg::cfg_t       cfg;
	tpid_pkg::s1_item_t   in_item;
	logic                 valid_s2;
	logic                 ready_s3;
	logic                 valid_s3;
	logic                 ready_s4;
	tpid_pkg::s2_front_t  front_s2;
	tpid_pkg::s3_prod_t   prod_s3;

	always_comb begin
		in_item.touch_x     = sample.touch_x;
		in_item.touch_y     = sample.touch_y;
		in_item.target_x    = sample.target_x;
		in_item.target_y    = sample.target_y;
		in_item.now_pos[0]  = sample.now_pos_a;
		in_item.now_pos[1]  = sample.now_pos_b;
		in_item.now_pos[2]  = sample.now_pos_c;
		in_item.goal_pos[0] = sample.goal_pos_a;
		in_item.goal_pos[1] = sample.goal_pos_b;
		in_item.goal_pos[2] = sample.goal_pos_c;
	end

	tpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tpid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (sample.valid),
		.in_item  (in_item),
		.in_ready (sample.ready),
		.valid_s2 (valid_s2),
		.front_s2 (front_s2),
		.ready_s3 (ready_s3)
	);

	tpid_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.front_s2 (front_s2),
		.ready_s3 (ready_s3),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.ready_s4 (ready_s4)
	);

	tpid_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.ready_s4 (ready_s4),
		.command  (command)
	);

endmodule

// ----- rtl/tpid_cfg.sv -----
// Configuration register file: gains, pad centers and limits, written by index.
// Depends on tpid_pkg.
module tpid_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output tpid_pkg::cfg_t                      cfg
);

	tpid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p           <= tpid_pkg::RST_GAIN_P;
			cfg_q.gain_i           <= tpid_pkg::RST_GAIN_I;
			cfg_q.gain_d           <= tpid_pkg::RST_GAIN_D;
			cfg_q.center_x         <= tpid_pkg::RST_CENTER;
			cfg_q.center_y         <= tpid_pkg::RST_CENTER;
			cfg_q.speed_gain       <= tpid_pkg::RST_SPEED_GAIN;
			cfg_q.tilt_limit       <= tpid_pkg::RST_TILT_LIMIT;
			cfg_q.speed_step_limit <= tpid_pkg::RST_SPEED_STEP;
		end else if (cfg_we) begin
			case (tpid_pkg::cfg_idx_t'(cfg_index))
				tpid_pkg::CFG_GAIN_P: begin
					cfg_q.gain_p <= cfg_wdata[tpid_pkg::GAIN_W-1:0];
				end
				tpid_pkg::CFG_GAIN_I: begin
					cfg_q.gain_i <= cfg_wdata[tpid_pkg::GAIN_W-1:0];
				end
				tpid_pkg::CFG_GAIN_D: begin
					cfg_q.gain_d <= cfg_wdata[tpid_pkg::GAIN_W-1:0];
				end
				tpid_pkg::CFG_CENTER_X: begin
					cfg_q.center_x <= cfg_wdata[tpid_pkg::CENTER_W-1:0];
				end
				tpid_pkg::CFG_CENTER_Y: begin
					cfg_q.center_y <= cfg_wdata[tpid_pkg::CENTER_W-1:0];
				end
				tpid_pkg::CFG_SPEED_GAIN: begin
					cfg_q.speed_gain <= cfg_wdata[tpid_pkg::SGAIN_W-1:0];
				end
				tpid_pkg::CFG_TILT_LIMIT: begin
					cfg_q.tilt_limit <= cfg_wdata[tpid_pkg::TLIM_W-1:0];
				end
				tpid_pkg::CFG_SPEED_STEP: begin
					cfg_q.speed_step_limit <= cfg_wdata[tpid_pkg::SPEED_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/tpid_front.sv -----
// Input register and error stage: per-axis error, saturating running sum, derivative,
// and the motor position gap times speed gain. Depends on tpid_pkg.
module tpid_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpid_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	input  tpid_pkg::s1_item_t   in_item,
	output logic                 in_ready,
	output logic                 valid_s2,
	output tpid_pkg::s2_front_t  front_s2,
	input  logic                 ready_s3
);

	logic                 valid_s1;
	tpid_pkg::s1_item_t   item_s1;
	logic                 ready_s2;
	logic                 load_s2;
	tpid_pkg::s2_front_t  front_d;

	tpid_pkg::err_t  last_err_q [tpid_pkg::AXES];
	tpid_pkg::sum_t  err_sum_q  [tpid_pkg::AXES];

	tpid_pkg::touch_t               touch  [tpid_pkg::AXES];
	logic [tpid_pkg::CENTER_W-1:0]  center [tpid_pkg::AXES];
	tpid_pkg::target_t              target [tpid_pkg::AXES];
	tpid_pkg::sumx_t                sum_x  [tpid_pkg::AXES];
	tpid_pkg::gapd_t                gap_d  [tpid_pkg::MOTOR_COUNT];
	tpid_pkg::gapd_t                gap_m  [tpid_pkg::MOTOR_COUNT];

	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = !valid_s1 || ready_s2;
	assign load_s2  = valid_s1 && ready_s2;

	always_comb begin
		touch[0]  = item_s1.touch_x;
		touch[1]  = item_s1.touch_y;
		center[0] = cfg.center_x;
		center[1] = cfg.center_y;
		target[0] = item_s1.target_x;
		target[1] = item_s1.target_y;
		front_d.nz = |item_s1.touch_x;
		for (int k = 0; k < tpid_pkg::AXES; k++) begin
			front_d.err[k] = tpid_pkg::err_t'(center[k]) - tpid_pkg::err_t'(touch[k])
				- tpid_pkg::err_t'(target[k]);
			sum_x[k] = tpid_pkg::sumx_t'(err_sum_q[k]) + tpid_pkg::sumx_t'($signed(front_d.err[k]))
				+ tpid_pkg::sumx_t'(last_err_q[k]);
			if (sum_x[k] > tpid_pkg::sumx_t'(tpid_pkg::SUM_MAX)) begin
				front_d.sum[k] = tpid_pkg::SUM_MAX;
			end else if (sum_x[k] < tpid_pkg::sumx_t'(tpid_pkg::SUM_MIN)) begin
				front_d.sum[k] = tpid_pkg::SUM_MIN;
			end else begin
				front_d.sum[k] = sum_x[k][tpid_pkg::SUM_W-1:0];
			end
			front_d.der[k] = tpid_pkg::der_t'($signed(front_d.err[k]))
				- tpid_pkg::der_t'(last_err_q[k]);
		end
		for (int m = 0; m < tpid_pkg::MOTOR_COUNT; m++) begin
			gap_d[m] = tpid_pkg::gapd_t'($signed(item_s1.now_pos[m]))
				- tpid_pkg::gapd_t'($signed(item_s1.goal_pos[m]));
			gap_m[m] = gap_d[m][tpid_pkg::POS_W] ? -gap_d[m] : gap_d[m];
			front_d.sprod[m] = tpid_pkg::sprod_t'(gap_m[m][tpid_pkg::GAP_W-1:0])
				* tpid_pkg::sprod_t'(cfg.speed_gain);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int k = 0; k < tpid_pkg::AXES; k++) begin
				last_err_q[k] <= '0;
				err_sum_q[k]  <= '0;
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			// A sample with no ball leaves the loop state untouched.
			if (load_s2 && front_d.nz) begin
				for (int k = 0; k < tpid_pkg::AXES; k++) begin
					last_err_q[k] <= front_d.err[k];
					err_sum_q[k]  <= front_d.sum[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (load_s2) begin
			front_s2 <= front_d;
		end
	end

endmodule

// ----- rtl/tpid_mult.sv -----
// Gain multiply stage for both axes, plus the motor speed slew and range limit,
// which keeps the last speed of each motor. Depends on tpid_pkg.
module tpid_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpid_pkg::cfg_t       cfg,
	input  logic                 valid_s2,
	input  tpid_pkg::s2_front_t  front_s2,
	output logic                 ready_s3,
	output logic                 valid_s3,
	output tpid_pkg::s3_prod_t   prod_s3,
	input  logic                 ready_s4
);

	logic                 load_s3;
	tpid_pkg::s3_prod_t   prod_d;
	tpid_pkg::gain_sx_t   gp;
	tpid_pkg::gain_sx_t   gi;
	tpid_pkg::gain_sx_t   gd;
	tpid_pkg::slew_t      lo   [tpid_pkg::MOTOR_COUNT];
	tpid_pkg::slew_t      hi   [tpid_pkg::MOTOR_COUNT];
	tpid_pkg::slew_t      slew [tpid_pkg::MOTOR_COUNT];
	tpid_pkg::speed_t     last_speed_q [tpid_pkg::MOTOR_COUNT];

	assign ready_s3 = !valid_s3 || ready_s4;
	assign load_s3  = valid_s2 && ready_s3;

	always_comb begin
		gp = $signed({1'b0, cfg.gain_p});
		gi = $signed({1'b0, cfg.gain_i});
		gd = $signed({1'b0, cfg.gain_d});
		prod_d.nz = front_s2.nz;
		for (int k = 0; k < tpid_pkg::AXES; k++) begin
			prod_d.pp[k] = tpid_pkg::pp_t'(gp) * tpid_pkg::pp_t'($signed(front_s2.err[k]));
			prod_d.pi[k] = tpid_pkg::pi_t'(gi) * tpid_pkg::pi_t'($signed(front_s2.sum[k]));
			prod_d.pd[k] = tpid_pkg::pd_t'(gd) * tpid_pkg::pd_t'($signed(front_s2.der[k]));
		end
		// Slew window first, then the absolute speed range; the window may reach past it.
		for (int m = 0; m < tpid_pkg::MOTOR_COUNT; m++) begin
			lo[m] = tpid_pkg::slew_t'(last_speed_q[m]) - tpid_pkg::slew_t'(cfg.speed_step_limit);
			hi[m] = tpid_pkg::slew_t'(last_speed_q[m]) + tpid_pkg::slew_t'(cfg.speed_step_limit);
			slew[m] = tpid_pkg::slew_t'(front_s2.sprod[m]);
			if (slew[m] < lo[m]) begin
				slew[m] = lo[m];
			end else if (slew[m] > hi[m]) begin
				slew[m] = hi[m];
			end
			if (slew[m] < tpid_pkg::slew_t'(0)) begin
				slew[m] = '0;
			end else if (slew[m] > tpid_pkg::slew_t'(tpid_pkg::SPEED_MAX)) begin
				slew[m] = tpid_pkg::slew_t'(tpid_pkg::SPEED_MAX);
			end
			prod_d.speed[m] = front_s2.nz ? slew[m][tpid_pkg::SPEED_W-1:0] : last_speed_q[m];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			for (int m = 0; m < tpid_pkg::MOTOR_COUNT; m++) begin
				last_speed_q[m] <= '0;
			end
		end else begin
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (load_s3) begin
				for (int m = 0; m < tpid_pkg::MOTOR_COUNT; m++) begin
					last_speed_q[m] <= prod_d.speed[m];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			prod_s3 <= prod_d;
		end
	end

endmodule

// ----- rtl/tpid_out.sv -----
// Sum of the three gain terms, tilt clamp and rounding to Q1.15, held tilt,
// ball-detect flags and the command output register. Depends on tpid_pkg and tpid_out_if.
module tpid_out (
	input  logic                clk,
	input  logic                arst_n,
	input  tpid_pkg::cfg_t      cfg,
	input  logic                valid_s3,
	input  tpid_pkg::s3_prod_t  prod_s3,
	output logic                ready_s4,
	tpid_out_if.source          command
);

	logic                valid_s4;
	tpid_pkg::s4_acc_t   acc_s4;
	tpid_pkg::s4_acc_t   acc_d;
	logic                ready_o;
	logic                load_s4;
	logic                load_o;
	logic                out_valid_q;

	tpid_pkg::acc_w_t    lim;
	tpid_pkg::acc_w_t    clip  [tpid_pkg::AXES];
	tpid_pkg::acc_w_t    rnd   [tpid_pkg::AXES];
	tpid_pkg::tilt_t     tilt_n [tpid_pkg::AXES];
	tpid_pkg::tilt_t     tilt_hold_q [tpid_pkg::AXES];
	tpid_pkg::tilt_t     tilt_q [tpid_pkg::AXES];
	tpid_pkg::speed_t    speed_q [tpid_pkg::MOTOR_COUNT];
	logic                seen_q;
	logic                prior_zero_q;
	logic                seen_n;
	logic                ball_q;

	assign ready_o  = !out_valid_q || command.ready;
	assign ready_s4 = !valid_s4 || ready_o;
	assign load_s4  = valid_s3 && ready_s4;
	assign load_o   = valid_s4 && ready_o;

	always_comb begin
		acc_d.nz    = prod_s3.nz;
		acc_d.speed = prod_s3.speed;
		for (int k = 0; k < tpid_pkg::AXES; k++) begin
			acc_d.acc[k] = tpid_pkg::acc_w_t'($signed(prod_s3.pp[k]))
				+ tpid_pkg::acc_w_t'($signed(prod_s3.pi[k]))
				+ tpid_pkg::acc_w_t'($signed(prod_s3.pd[k]));
		end
	end

	always_comb begin
		lim = tpid_pkg::acc_w_t'({cfg.tilt_limit, {tpid_pkg::ROUND_SH{1'b0}}});
		for (int k = 0; k < tpid_pkg::AXES; k++) begin
			clip[k] = $signed(acc_s4.acc[k]);
			if (clip[k] < -lim) begin
				clip[k] = -lim;
			end else if (clip[k] > lim) begin
				clip[k] = lim;
			end
			// Arithmetic shift floors, so adding half an LSB first rounds half up.
			rnd[k] = (clip[k] + tpid_pkg::acc_w_t'(tpid_pkg::ROUND_HALF)) >>> tpid_pkg::ROUND_SH;
			tilt_n[k] = acc_s4.nz ? rnd[k][tpid_pkg::TILT_W-1:0] : tilt_hold_q[k];
		end
		// Detection drops only on the second zero sample in a row.
		if (acc_s4.nz) begin
			seen_n = 1'b1;
		end else if (prior_zero_q) begin
			seen_n = 1'b0;
		end else begin
			seen_n = seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4     <= 1'b0;
			out_valid_q  <= 1'b0;
			seen_q       <= 1'b0;
			prior_zero_q <= 1'b0;
			for (int k = 0; k < tpid_pkg::AXES; k++) begin
				tilt_hold_q[k] <= '0;
			end
		end else begin
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_o) begin
				out_valid_q <= valid_s4;
			end
			if (load_o) begin
				seen_q       <= seen_n;
				prior_zero_q <= !acc_s4.nz;
				for (int k = 0; k < tpid_pkg::AXES; k++) begin
					tilt_hold_q[k] <= tilt_n[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			acc_s4 <= acc_d;
		end
		if (load_o) begin
			ball_q <= seen_n;
			for (int k = 0; k < tpid_pkg::AXES; k++) begin
				tilt_q[k] <= tilt_n[k];
			end
			for (int m = 0; m < tpid_pkg::MOTOR_COUNT; m++) begin
				speed_q[m] <= acc_s4.speed[m];
			end
		end
	end

	assign command.valid     = out_valid_q;
	assign command.tilt_x    = tilt_q[0];
	assign command.tilt_y    = tilt_q[1];
	assign command.speed_a   = speed_q[0];
	assign command.speed_b   = speed_q[1];
	assign command.speed_c   = speed_q[2];
	assign command.ball_seen = ball_q;

endmodule

// ----- rtl/tpid_checker.sv -----
// Port-level checks of the two-axis PID unit, attached to the top level by bind.
// Depends on tpid_pkg.
module tpid_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_ready,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  tpid_pkg::tilt_t   tilt_x,
	input  tpid_pkg::tilt_t   tilt_y,
	input  tpid_pkg::speed_t  speed_a,
	input  tpid_pkg::speed_t  speed_b,
	input  tpid_pkg::speed_t  speed_c,
	input  logic              ball_seen
);

	// No command beat is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !cmd_valid)
		else $error("command valid during reset");

	// Samples are refused only when every stage is full behind a stalled command beat.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> cmd_valid && !cmd_ready)
		else $error("sample refused without a stalled command beat");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> speed_a <= tpid_pkg::speed_t'(tpid_pkg::SPEED_MAX)
			&& speed_b <= tpid_pkg::speed_t'(tpid_pkg::SPEED_MAX)
			&& speed_c <= tpid_pkg::speed_t'(tpid_pkg::SPEED_MAX))
		else $error("motor speed above range");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("command beat dropped while stalled");

	a_cmd_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> $stable(tilt_x) && $stable(tilt_y) && $stable(speed_a)
			&& $stable(speed_b) && $stable(speed_c) && $stable(ball_seen))
		else $error("command payload changed while stalled");

endmodule

bind two_axis_pid_with_motor_speed_unit tpid_checker u_tpid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample.ready),
	.cmd_valid    (command.valid),
	.cmd_ready    (command.ready),
	.tilt_x       (command.tilt_x),
	.tilt_y       (command.tilt_y),
	.speed_a      (command.speed_a),
	.speed_b      (command.speed_b),
	.speed_c      (command.speed_c),
	.ball_seen    (command.ball_seen)
);
